FILE: design/postfix_expression_evaluator_top_defines.svh
// Assertion macros shared by the postfix evaluator RTL.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define PEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PEE_ASSERT(lbl, prop, msg)
`define PEE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/pee_pkg.sv
// Shared constants and types of the postfix expression evaluator.
`default_nettype none
package pee_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_MOD  = 8'h25;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_NL   = 8'h0A;

  // Status codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;

  // Iterative unit operations
  localparam logic [1:0] ALU_MUL = 2'd0;
  localparam logic [1:0] ALU_DIV = 2'd1;
  localparam logic [1:0] ALU_MOD = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic divz;
  } alu_rsp_t;

endpackage
`default_nettype wire

FILE: design/pee_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/pee_alu.sv
// Shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none
module pee_alu #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  pee_pkg::alu_req_t  req,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output pee_pkg::alu_rsp_t  rsp,
  output logic [W-1:0]       result
);

  localparam int SW = $clog2(W);

  logic          busy;
  logic          done;
  logic          divz;
  logic [1:0]    op;
  logic [SW-1:0] step;
  logic [W:0]    work;    // accumulator or partial remainder
  logic [W-1:0]  opnd;    // multiplicand or divisor magnitude
  logic [W-1:0]  shreg;   // multiplier or dividend / quotient
  logic          neg_q;
  logic          neg_r;

  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic [W-1:0]  addend;

  always_comb begin
    mag_a  = a[W-1] ? W'(0) - a : a;
    mag_b  = b[W-1] ? W'(0) - b : b;
    rem_sh = {work[W-1:0], shreg[W-1]};
    diff   = rem_sh - {1'b0, opnd};
    addend = shreg[0] ? opnd : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      divz <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op   <= req.op;
        divz <= 1'b0;
        step <= '0;
        work <= '0;
        if (req.op == pee_pkg::ALU_MUL) begin
          opnd  <= a;
          shreg <= b;
          busy  <= 1'b1;
        end else if (mag_b == '0) begin
          divz <= 1'b1;
          done <= 1'b1;
        end else begin
          opnd  <= mag_b;
          shreg <= mag_a;
          neg_q <= a[W-1] ^ b[W-1];
          neg_r <= a[W-1];
          busy  <= 1'b1;
        end
      end else if (busy) begin
        if (op == pee_pkg::ALU_MUL) begin
          work  <= {1'b0, work[W-1:0] + addend};
          opnd  <= {opnd[W-2:0], 1'b0};
          shreg <= {1'b0, shreg[W-1:1]};
        end else if (!diff[W]) begin
          work  <= diff;
          shreg <= {shreg[W-2:0], 1'b1};
        end else begin
          work  <= rem_sh;
          shreg <= {shreg[W-2:0], 1'b0};
        end
        step <= step + SW'(1);
        if (step == SW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.divz = divz;
    if (divz) begin
      result = '0;
    end else if (op == pee_pkg::ALU_MUL) begin
      result = work[W-1:0];
    end else if (op == pee_pkg::ALU_DIV) begin
      result = neg_q ? W'(0) - shreg : shreg;
    end else begin
      result = neg_r ? W'(0) - work[W-1:0] : work[W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: design/postfix_expression_evaluator_top.sv
// Postfix expression evaluator: operand stack in RAM, iterative multiply/divide.
//
// Characters arrive one per request. A space, newline or parenthesis is
// dropped and a digit (or any other non-operator) is pushed onto the stack.
// + and - read the two top stack entries in turn and write the result back.
// * / % go through the shared unit that retires one product or quotient
// bit per cycle; a divide by zero skips the bit loop. A NUL reads the top
// of the stack (skipped on an error or an empty stack) and loads the result
// register once it is free, then the next character is taken while the
// result still waits downstream. The stack holds STACK_DEPTH entries.
`default_nettype none
`include "postfix_expression_evaluator_top_defines.svh"
module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] value,
  output logic [1:0]         status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDB  = 3'd1;
  localparam logic [2:0] S_RDA  = 3'd2;
  localparam logic [2:0] S_ALU  = 3'd3;
  localparam logic [2:0] S_TOP  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  localparam logic [1:0] K_PUSH = 2'd0;
  localparam logic [1:0] K_IGN  = 2'd1;
  localparam logic [1:0] K_OP   = 2'd2;
  localparam logic [1:0] K_END  = 2'd3;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [1:0]    err_code;
  logic [7:0]    op_char;
  logic [VW-1:0] b_val;
  logic [31:0]   pend_val;
  logic [1:0]    pend_st;

  logic          char_acc;
  logic [1:0]    kind;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] count_m2;
  logic          full;
  logic          add_sub;
  logic [63:0]   digit_wide;
  logic [63:0]   top_wide;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  pee_pkg::alu_req_t alu_req;
  pee_pkg::alu_rsp_t alu_rsp;
  logic [VW-1:0]     alu_res;

  assign char_stall = (state != S_IDLE);
  assign char_acc   = char_valid && !char_stall;
  assign count_m1   = count - CW'(1);
  assign count_m2   = count - CW'(2);
  assign full       = (count == CW'(STACK_DEPTH));
  assign add_sub    = (op_char == pee_pkg::CH_ADD) || (op_char == pee_pkg::CH_SUB);
  assign digit_wide = {56'b0, char_in} - {56'b0, pee_pkg::CH_ZERO};
  assign top_wide   = 64'(ram_rdata);

  always_comb begin
    case (char_in) inside
      pee_pkg::CH_NUL:                                    kind = K_END;
      pee_pkg::CH_LPAR, pee_pkg::CH_RPAR,
      pee_pkg::CH_SP, pee_pkg::CH_NL:                     kind = K_IGN;
      pee_pkg::CH_ADD, pee_pkg::CH_SUB, pee_pkg::CH_MUL,
      pee_pkg::CH_DIV, pee_pkg::CH_MOD:                   kind = K_OP;
      default:                                            kind = K_PUSH;
    endcase
  end

  always_comb begin
    alu_req.start = (state == S_RDA) && !add_sub;
    case (op_char)
      pee_pkg::CH_MUL: alu_req.op = pee_pkg::ALU_MUL;
      pee_pkg::CH_DIV: alu_req.op = pee_pkg::ALU_DIV;
      default:         alu_req.op = pee_pkg::ALU_MOD;
    endcase
  end

  // Stack RAM ports: push at count, pop-two-push-one writes at count - 2.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = digit_wide[VW-1:0];
    ram_raddr = count_m1[AW-1:0];
    case (state)
      S_IDLE: begin
        ram_we = char_acc && (kind == K_PUSH) && !full;
      end
      S_RDB: begin
        ram_raddr = count_m2[AW-1:0];
      end
      S_RDA: begin
        ram_waddr = count_m2[AW-1:0];
        ram_we    = add_sub;
        ram_wdata = (op_char == pee_pkg::CH_ADD) ? ram_rdata + b_val : ram_rdata - b_val;
      end
      S_ALU: begin
        ram_waddr = count_m2[AW-1:0];
        ram_we    = alu_rsp.done;
        ram_wdata = alu_res;
      end
      default: ;
    endcase
  end

  pee_ram #(
    .WIDTH(VW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pee_alu #(
    .W(VW)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .a     (ram_rdata),
    .b     (b_val),
    .rsp   (alu_rsp),
    .result(alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      err_code     <= pee_pkg::ERR_NONE;
      result_valid <= 1'b0;
    end else begin
      // The emit state reloads the result register itself when it frees up.
      if (result_valid && !result_stall && (state != S_EMIT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (char_acc) begin
            case (kind)
              K_PUSH: begin
                if (!full) begin
                  count <= count + CW'(1);
                end else if (err_code == pee_pkg::ERR_NONE) begin
                  err_code <= pee_pkg::ERR_OVER;
                end
              end
              K_OP: begin
                if (count >= CW'(2)) begin
                  op_char <= char_in;
                  state   <= S_RDB;
                end else if (err_code == pee_pkg::ERR_NONE) begin
                  err_code <= pee_pkg::ERR_UNDER;
                end
              end
              K_END: begin
                // Drop the stack and held error; S_TOP, if taken, reads the top.
                count    <= '0;
                err_code <= pee_pkg::ERR_NONE;
                pend_val <= '0;
                if (err_code != pee_pkg::ERR_NONE) begin
                  pend_st <= err_code;
                  state   <= S_EMIT;
                end else if (count == '0) begin
                  pend_st <= pee_pkg::ERR_UNDER;
                  state   <= S_EMIT;
                end else begin
                  pend_st <= pee_pkg::ERR_NONE;
                  state   <= S_TOP;
                end
              end
              default: ;
            endcase
          end
        end
        S_RDB: begin
          b_val <= ram_rdata;
          state <= S_RDA;
        end
        S_RDA: begin
          if (add_sub) begin
            count <= count_m1;
            state <= S_IDLE;
          end else begin
            state <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_rsp.done) begin
            count <= count_m1;
            if (alu_rsp.divz && (err_code == pee_pkg::ERR_NONE)) begin
              err_code <= pee_pkg::ERR_DIVZ;
            end
            state <= S_IDLE;
          end
        end
        S_TOP: begin
          pend_val <= top_wide[31:0];
          state    <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the result register is free.
          if (!result_valid || !result_stall) begin
            value        <= pend_val;
            status       <= pend_st;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PEE_ASSERT(a_count_bound, count <= CW'(STACK_DEPTH), "stack count beyond depth")
  `PEE_ASSERT(a_emit_source, $rose(result_valid) |-> $past(state) == S_EMIT, "result not from emit")
  `PEE_ASSERT(a_end_clears, (char_acc && (kind == K_END)) |=> (count == '0) && (err_code == pee_pkg::ERR_NONE), "end did not clear stack")
  `PEE_ASSERT(a_alu_owner, alu_rsp.done |-> state == S_ALU, "unit finished outside its wait")
  `PEE_ASSERT_ALWAYS(a_reset_out, rst |=> !result_valid, "result valid after reset")

endmodule
`default_nettype wire
